FILE: src/ivtp_pkg.sv
// Package for the integer vector text parser: character codes, parser phase
// codes, result kinds, error codes and the result and push types.
// No dependencies.
`default_nettype none

package ivtp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MAG_W   = 63;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned PHASE_W = 3;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [PHASE_W-1:0] PH_OPEN  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ELEM  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_MINUS = 3'd3;
  localparam logic [PHASE_W-1:0] PH_NUM   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SEP   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd6;

  localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  localparam logic [CODE_W-1:0] ERR_NONE           = 3'd0;
  localparam logic [CODE_W-1:0] ERR_EXPECT_OPEN    = 3'd1;
  localparam logic [CODE_W-1:0] ERR_EXPECT_INTEGER = 3'd2;
  localparam logic [CODE_W-1:0] ERR_EXPECT_CLOSE   = 3'd3;
  localparam logic [CODE_W-1:0] ERR_OVERFLOW       = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [CODE_W-1:0]         error_code;
    logic                      last_of_run;
  } result_t;

  // Results produced by one character, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

FILE: src/ivtp_if.sv
// Valid/ready channel interfaces for the integer vector text parser:
// the character input channel and the result output channel.
// Depends on ivtp_pkg.
`default_nettype none

interface ivtp_char_if;
  logic                            valid;
  logic                            ready;
  logic [ivtp_pkg::CHAR_W-1:0]     character;
  logic                            end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface ivtp_result_if;
  logic                                valid;
  logic                                ready;
  logic [ivtp_pkg::KIND_W-1:0]         kind;
  logic signed [ivtp_pkg::VALUE_W-1:0] value;
  logic [ivtp_pkg::CODE_W-1:0]         error_code;
  logic                                last_of_run;

  modport source (output valid, output kind, output value, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input value, input error_code,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/ivtp_core.sv
// Parser core: input character register, parse state registers and the
// single-pass step logic that yields up to two results per character.
// Depends on ivtp_pkg and ivtp_char_if.
`default_nettype none

module ivtp_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  ivtp_char_if.sink            in_i,
  input  wire logic            room_i,
  output ivtp_pkg::push_t      push_o
);

  logic                               in_valid_q;
  logic [ivtp_pkg::CHAR_W-1:0]        char_q;
  logic                               eoi_q;
  logic                               fire;

  logic [ivtp_pkg::PHASE_W-1:0]       phase_q, phase_d;
  logic                               neg_q, neg_d;
  logic [ivtp_pkg::MAG_W-1:0]         mag_q, mag_d;

  logic                               is_ws, is_digit;
  logic [ivtp_pkg::MAG_W+3:0]         mac;
  logic                               ovf;
  logic [ivtp_pkg::MAG_W-1:0]         digit_mag;

  logic                               has_elem, has_term;
  logic                               elem_neg;
  logic [ivtp_pkg::MAG_W-1:0]         elem_mag;
  logic [ivtp_pkg::VALUE_W-1:0]       elem_val;
  logic [ivtp_pkg::KIND_W-1:0]        term_kind;
  logic [ivtp_pkg::CODE_W-1:0]        term_code;
  ivtp_pkg::result_t                  elem_res, term_res;

  assign in_i.ready = !in_valid_q || room_i;
  assign fire       = in_valid_q && room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.character;
      eoi_q  <= in_i.end_of_input;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ivtp_pkg::PH_OPEN;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

  assign is_ws = (char_q >= ivtp_pkg::CH_TAB && char_q <= ivtp_pkg::CH_CR) ||
                 char_q == ivtp_pkg::CH_SPACE;
  assign is_digit = char_q >= ivtp_pkg::CH_ZERO && char_q <= ivtp_pkg::CH_NINE;
  assign digit_mag = {{(ivtp_pkg::MAG_W-4){1'b0}}, char_q[3:0]};

  // magnitude * 10 + digit, overflow when above 2^63-1
  assign mac = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} +
               {{ivtp_pkg::MAG_W{1'b0}}, char_q[3:0]};
  assign ovf = |mac[ivtp_pkg::MAG_W+3:ivtp_pkg::MAG_W];

  always_comb begin
    phase_d   = phase_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    has_elem  = 1'b0;
    has_term  = 1'b0;
    elem_neg  = neg_q;
    elem_mag  = mag_q;
    term_kind = ivtp_pkg::KIND_DONE;
    term_code = ivtp_pkg::ERR_NONE;

    case (phase_q)
      ivtp_pkg::PH_OPEN: begin
        if (is_ws) begin
          phase_d = phase_q;
        end else if (char_q == ivtp_pkg::CH_OPEN) begin
          phase_d = ivtp_pkg::PH_FIRST;
        end else begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_OPEN;
          phase_d   = ivtp_pkg::PH_DONE;
        end
      end
      ivtp_pkg::PH_FIRST, ivtp_pkg::PH_ELEM: begin
        if (is_ws) begin
          phase_d = phase_q;
        end else if (phase_q == ivtp_pkg::PH_FIRST && char_q == ivtp_pkg::CH_CLOSE) begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_DONE;
          phase_d   = ivtp_pkg::PH_DONE;
        end else if (char_q == ivtp_pkg::CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = ivtp_pkg::PH_MINUS;
        end else if (is_digit) begin
          mag_d   = digit_mag;
          phase_d = ivtp_pkg::PH_NUM;
        end else begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_INTEGER;
          phase_d   = ivtp_pkg::PH_DONE;
        end
      end
      ivtp_pkg::PH_MINUS: begin
        if (is_digit) begin
          mag_d   = digit_mag;
          phase_d = ivtp_pkg::PH_NUM;
        end else begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_INTEGER;
          phase_d   = ivtp_pkg::PH_DONE;
        end
      end
      ivtp_pkg::PH_NUM, ivtp_pkg::PH_SEP: begin
        if (phase_q == ivtp_pkg::PH_NUM && is_digit) begin
          if (ovf) begin
            has_term  = 1'b1;
            term_kind = ivtp_pkg::KIND_ERROR;
            term_code = ivtp_pkg::ERR_OVERFLOW;
            phase_d   = ivtp_pkg::PH_DONE;
          end else begin
            mag_d = mac[ivtp_pkg::MAG_W-1:0];
          end
        end else begin
          if (phase_q == ivtp_pkg::PH_NUM) begin
            // integer ends here, same character is then a separator
            has_elem = 1'b1;
            neg_d    = 1'b0;
            mag_d    = '0;
          end
          if (is_ws) begin
            phase_d = ivtp_pkg::PH_SEP;
          end else if (char_q == ivtp_pkg::CH_COMMA) begin
            phase_d = ivtp_pkg::PH_ELEM;
          end else if (char_q == ivtp_pkg::CH_CLOSE) begin
            has_term  = 1'b1;
            term_kind = ivtp_pkg::KIND_DONE;
            phase_d   = ivtp_pkg::PH_DONE;
          end else begin
            has_term  = 1'b1;
            term_kind = ivtp_pkg::KIND_ERROR;
            term_code = ivtp_pkg::ERR_EXPECT_CLOSE;
            phase_d   = ivtp_pkg::PH_DONE;
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (eoi_q) begin
      case (phase_d)
        ivtp_pkg::PH_OPEN: begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_OPEN;
        end
        ivtp_pkg::PH_FIRST, ivtp_pkg::PH_ELEM, ivtp_pkg::PH_MINUS: begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_INTEGER;
        end
        ivtp_pkg::PH_NUM: begin
          has_elem  = 1'b1;
          elem_neg  = neg_d;
          elem_mag  = mag_d;
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_CLOSE;
        end
        ivtp_pkg::PH_SEP: begin
          has_term  = 1'b1;
          term_kind = ivtp_pkg::KIND_ERROR;
          term_code = ivtp_pkg::ERR_EXPECT_CLOSE;
        end
        default: begin
          has_term = has_term;
        end
      endcase
      phase_d = ivtp_pkg::PH_OPEN;
      neg_d   = 1'b0;
      mag_d   = '0;
    end
  end

  assign elem_val = elem_neg ? (ivtp_pkg::VALUE_W'(0) - {1'b0, elem_mag})
                             : {1'b0, elem_mag};

  assign elem_res.kind        = ivtp_pkg::KIND_ELEMENT;
  assign elem_res.value       = elem_val;
  assign elem_res.error_code  = ivtp_pkg::ERR_NONE;
  assign elem_res.last_of_run = !has_term;

  assign term_res.kind        = term_kind;
  assign term_res.value       = '0;
  assign term_res.error_code  = term_code;
  assign term_res.last_of_run = 1'b1;

  // an element, when present, always precedes the terminating result
  assign push_o.count  = fire ? ({1'b0, has_elem} + {1'b0, has_term}) : 2'd0;
  assign push_o.first  = has_elem ? elem_res : term_res;
  assign push_o.second = term_res;

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= ivtp_pkg::PH_DONE)
    else $error("parse phase holds an unused code");

  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eoi_q) |=> (phase_q == ivtp_pkg::PH_OPEN && mag_q == '0 && !neg_q))
    else $error("state not cleared after end of input");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |->
      (push_o.first.kind == ivtp_pkg::KIND_ELEMENT && push_o.second.kind != ivtp_pkg::KIND_ELEMENT))
    else $error("two results per character must be element then terminator");

endmodule

`default_nettype wire

FILE: src/ivtp_out_fifo.sv
// Result queue: takes zero, one or two results per cycle from the parser core
// and hands them out one transaction at a time. Depends on ivtp_pkg, ivtp_result_if.
`default_nettype none

module ivtp_out_fifo #(
  parameter int unsigned FifoDepth = ivtp_pkg::FIFO_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ivtp_pkg::push_t push_i,
  output logic                 room_o,
  ivtp_result_if.source        out_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  ivtp_pkg::result_t   mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q, wr_next;
  logic [CntW-1:0]     count_q;
  logic                pop;
  ivtp_pkg::result_t   head;

  function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] p, logic [1:0] k);
    int unsigned sum;
    sum = int'(p) + int'(k);
    if (sum >= FifoDepth) begin
      sum = sum - FifoDepth;
    end
    return PtrW'(sum);
  endfunction

  assign room_o  = count_q <= CntW'(FifoDepth - 2);
  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wrap_add(wr_ptr_q, 2'd1);
  assign head    = mem_q[rd_ptr_q];

  assign out_o.valid       = count_q != '0;
  assign out_o.kind        = head.kind;
  assign out_o.value       = head.value;
  assign out_o.error_code  = head.error_code;
  assign out_o.last_of_run = head.last_of_run;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wrap_add(wr_ptr_q, push_i.count);
      if (pop) begin
        rd_ptr_q <= wrap_add(rd_ptr_q, 2'd1);
      end
      count_q <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("results pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue count out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(1) && pop && push_i.count == 2'd0) |=> !out_o.valid)
    else $error("queue not empty after last transaction drained");

endmodule

`default_nettype wire

FILE: src/int_vector_text_parser.sv
// Top level of the integer vector text parser: parser core and result queue.
// Depends on ivtp_pkg, ivtp_if (ivtp_char_if, ivtp_result_if), ivtp_core, ivtp_out_fifo.
//
//   port   | dir | transaction
//   -------+-----+----------------------------------------------------------
//   in_i   | in  | one character, end_of_input marks the last of a frame
//   out_o  | out | one result: element, vector complete or error
//
// A character is taken into the input register, then parsed in one pass once the
// queue has room (multiply-by-ten accumulate plus phase update); one character per cycle
// is sustained while the queue has room, and it yields zero, one or two results.
// Results enter a FifoDepth-entry queue; input is held off only while the queue
// has fewer than two free entries, so out_o stalls reach in_i through a register.
// Reset is asynchronous, active low; no clearing pass is needed.
`default_nettype none

module int_vector_text_parser #(
  parameter int unsigned FifoDepth = ivtp_pkg::FIFO_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ivtp_char_if.sink      in_i,
  ivtp_result_if.source  out_o
);

  ivtp_pkg::push_t push;
  logic            room;

  ivtp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  ivtp_out_fifo #(
    .FifoDepth (FifoDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
